>>> hdl/ihex_pkg.sv
// Shared types, character codes and helper functions for the Intel HEX encoder.
// No dependencies; imported by every module of the block.
package ihex_pkg;

    // ASCII codes used in the record text
    localparam logic [6:0] CHAR_COLON = 7'h3A;
    localparam logic [6:0] CHAR_ZERO  = 7'h30;
    localparam logic [6:0] CHAR_ONE   = 7'h31;
    localparam logic [6:0] CHAR_F     = 7'h46;
    localparam logic [6:0] CHAR_CR    = 7'h0D;
    localparam logic [6:0] CHAR_LF    = 7'h0A;

    // Character slots of one input item, in emission order
    localparam int SLOT_W = 5;
    localparam logic [SLOT_W-1:0] SLOT_COLON   = 5'd0;
    localparam logic [SLOT_W-1:0] SLOT_LEN_HI  = 5'd1;
    localparam logic [SLOT_W-1:0] SLOT_LEN_LO  = 5'd2;
    localparam logic [SLOT_W-1:0] SLOT_AHI_HI  = 5'd3;
    localparam logic [SLOT_W-1:0] SLOT_AHI_LO  = 5'd4;
    localparam logic [SLOT_W-1:0] SLOT_ALO_HI  = 5'd5;
    localparam logic [SLOT_W-1:0] SLOT_ALO_LO  = 5'd6;
    localparam logic [SLOT_W-1:0] SLOT_TYPE_HI = 5'd7;
    localparam logic [SLOT_W-1:0] SLOT_TYPE_LO = 5'd8;
    localparam logic [SLOT_W-1:0] SLOT_DATA_HI = 5'd9;
    localparam logic [SLOT_W-1:0] SLOT_DATA_LO = 5'd10;
    localparam logic [SLOT_W-1:0] SLOT_CKS_HI  = 5'd11;
    localparam logic [SLOT_W-1:0] SLOT_CKS_LO  = 5'd12;
    localparam logic [SLOT_W-1:0] SLOT_CR      = 5'd13;
    localparam logic [SLOT_W-1:0] SLOT_LF      = 5'd14;
    localparam logic [SLOT_W-1:0] SLOT_END     = 5'd15;
    localparam logic [SLOT_W-1:0] SLOT_LAST    = 5'd27;

    // Work for one item, computed when it leaves the input register
    typedef struct packed {
        logic        hdr;    // record header first
        logic        close;  // checksum and CR LF after the data
        logic        last;   // end-of-file record after that
        logic [15:0] addr;   // record load address
        logic [7:0]  data;
        logic [7:0]  cks;
    } t_plan;

    // Uppercase hex digit
    function automatic logic [6:0] hex_char(input logic [3:0] v);
        hex_char = (v < 4'd10) ? (CHAR_ZERO + {3'b000, v}) : (7'h37 + {3'b000, v});
    endfunction

    // Characters of the end-of-file record ":00000001FF" CR LF
    function automatic logic [6:0] end_char(input logic [3:0] idx);
        logic [6:0] c;
        unique case (idx) inside
            4'd0:          c = CHAR_COLON;
            [4'd1:4'd7]:   c = CHAR_ZERO;
            4'd8:          c = CHAR_ONE;
            4'd9, 4'd10:   c = CHAR_F;
            4'd11:         c = CHAR_CR;
            4'd12:         c = CHAR_LF;
            default:       c = CHAR_ZERO;
        endcase
        end_char = c;
    endfunction

endpackage

>>> hdl/intel_hex_record_encoder.sv
// Top level of the Intel HEX record encoder: input register and planning, then
// the character sequencer with its output register. Depends on ihex_pkg, ihex_plan, ihex_char_gen.
//
// Usage:
//   Slave stream: one image byte per transfer in tdata, tlast marks the final byte.
//   Master stream: one ASCII character per transfer; tlast marks the last character
//   caused by an input byte.
//   i_cfg_wr_en/i_cfg_wr_data load the 16-bit base address; write only while idle.
//   Each byte gives 2 characters, plus 9 for a record header, 4 for checksum and
//   CR LF when a record closes, and 13 for the end record after a byte flagged last
//   (2 to 28 characters). One character leaves per cycle while the master side accepts;
//   the output register's single character per cycle sets that rate.
//   A first character passes the input register, slot register and output register.
//   The next byte is taken into the input register while the current one is still
//   being emitted, and is planned in the cycle its predecessor's final character
//   is registered, so characters stream without gaps.
//   Reset clears the base address, record offset, position and sum.
//   A stall on the master side holds the output register and backs up to o_s_axis_tready.
module intel_hex_record_encoder #(
    parameter int RECORD_BYTES = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [15:0] i_cfg_wr_data,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // [7:0] data_byte
    input  logic        i_s_axis_tlast,   // image_last
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [7:0]  o_m_axis_tdata,   // [6:0] char_code, [7] zero
    output logic        o_m_axis_tlast    // run_last
);
    import ihex_pkg::*;

    t_plan plan;
    logic  plan_valid;
    logic  plan_take;

    ihex_plan #(
        .RECORD_BYTES(RECORD_BYTES)
    ) u_plan (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_wr_data   (i_cfg_wr_data),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tlast  (i_s_axis_tlast),
        .o_plan_valid    (plan_valid),
        .i_plan_take     (plan_take),
        .o_plan          (plan)
    );

    ihex_char_gen #(
        .RECORD_BYTES(RECORD_BYTES)
    ) u_char_gen (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_plan_valid    (plan_valid),
        .o_plan_take     (plan_take),
        .i_plan          (plan),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

endmodule

>>> hdl/ihex_plan.sv
// Input register, record state (offset, position, checksum sum) and per-item planning.
// Depends on ihex_pkg.
module ihex_plan #(
    parameter int RECORD_BYTES = 32
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cfg_wr_en,
    input  logic [15:0]    i_cfg_wr_data,
    input  logic           i_s_axis_tvalid,
    output logic           o_s_axis_tready,
    input  logic [7:0]     i_s_axis_tdata,
    input  logic           i_s_axis_tlast,
    output logic           o_plan_valid,
    input  logic           i_plan_take,
    output ihex_pkg::t_plan o_plan
);
    import ihex_pkg::*;

    localparam logic [7:0] LEN = 8'(RECORD_BYTES);

    logic        r_ivalid;
    logic [7:0]  r_idata;
    logic        r_ilast;
    logic [15:0] r_base;
    logic [15:0] r_offset;
    logic [7:0]  r_pos;
    logic [7:0]  r_sum;

    logic        hdr;
    logic [15:0] addr;
    logic [7:0]  sum0;
    logic [7:0]  sum1;
    logic [7:0]  pos1;
    logic        close;
    logic        accept;

    assign o_s_axis_tready = !r_ivalid || i_plan_take;
    assign accept          = i_s_axis_tvalid && o_s_axis_tready;
    assign o_plan_valid    = r_ivalid;

    // Plan for the held item
    always_comb begin
        hdr   = (r_pos == 8'd0);
        addr  = r_base + r_offset;
        sum0  = hdr ? (LEN + addr[15:8] + addr[7:0]) : r_sum;
        sum1  = sum0 + r_idata;
        pos1  = r_pos + 8'd1;
        close = r_ilast || (pos1 >= LEN) || (pos1 == 8'd0);
        o_plan.hdr   = hdr;
        o_plan.close = close;
        o_plan.last  = r_ilast;
        o_plan.addr  = addr;
        o_plan.data  = r_idata;
        o_plan.cks   = 8'd0 - sum1;
    end

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ivalid <= 1'b0;
        end else if (accept) begin
            r_ivalid <= 1'b1;
        end else if (i_plan_take) begin
            r_ivalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_idata <= i_s_axis_tdata;
            r_ilast <= i_s_axis_tlast;
        end
    end

    // Base address, loaded on a configuration write, and record state, advanced when the sequencer takes the item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base   <= 16'd0;
            r_offset <= 16'd0;
            r_pos    <= 8'd0;
            r_sum    <= 8'd0;
        end else begin
            if (i_cfg_wr_en) begin
                r_base <= i_cfg_wr_data;
            end
            if (i_plan_take) begin
                r_offset <= r_ilast ? 16'd0 : (r_offset + 16'd1);
                r_pos    <= close ? 8'd0 : pos1;
                r_sum    <= close ? 8'd0 : sum1;
            end
        end
    end

endmodule

>>> hdl/ihex_char_gen.sv
// Character sequencer: walks the slots of one planned item and fills the output register.
// Depends on ihex_pkg.
module ihex_char_gen #(
    parameter int RECORD_BYTES = 32
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_plan_valid,
    output logic           o_plan_take,
    input  ihex_pkg::t_plan i_plan,
    output logic           o_m_axis_tvalid,
    input  logic           i_m_axis_tready,
    output logic [7:0]     o_m_axis_tdata,
    output logic           o_m_axis_tlast
);
    import ihex_pkg::*;

    localparam logic [7:0] LEN = 8'(RECORD_BYTES);

    t_plan             r_plan;
    logic              r_busy;
    logic [SLOT_W-1:0] r_slot;
    logic              r_ovalid;
    logic [6:0]        r_ochar;
    logic              r_olast;

    logic              adv;
    logic              fin;
    logic              take;
    logic [6:0]        ch;
    logic [3:0]        end_idx;
    logic [SLOT_W-1:0] n_slot;

    assign adv = !r_ovalid || i_m_axis_tready;

    // Last slot of the current item
    assign fin = ((r_slot == SLOT_DATA_LO) && !r_plan.close)
              || ((r_slot == SLOT_LF) && !r_plan.last)
              || (r_slot == SLOT_LAST);

    assign take        = i_plan_valid && (!r_busy || (adv && fin));
    assign o_plan_take = take;

    // Character of the current slot
    always_comb begin
        end_idx = 4'(r_slot - SLOT_END);
        case (r_slot)
            SLOT_COLON:   ch = CHAR_COLON;
            SLOT_LEN_HI:  ch = hex_char(LEN[7:4]);
            SLOT_LEN_LO:  ch = hex_char(LEN[3:0]);
            SLOT_AHI_HI:  ch = hex_char(r_plan.addr[15:12]);
            SLOT_AHI_LO:  ch = hex_char(r_plan.addr[11:8]);
            SLOT_ALO_HI:  ch = hex_char(r_plan.addr[7:4]);
            SLOT_ALO_LO:  ch = hex_char(r_plan.addr[3:0]);
            SLOT_TYPE_HI: ch = CHAR_ZERO;
            SLOT_TYPE_LO: ch = CHAR_ZERO;
            SLOT_DATA_HI: ch = hex_char(r_plan.data[7:4]);
            SLOT_DATA_LO: ch = hex_char(r_plan.data[3:0]);
            SLOT_CKS_HI:  ch = hex_char(r_plan.cks[7:4]);
            SLOT_CKS_LO:  ch = hex_char(r_plan.cks[3:0]);
            SLOT_CR:      ch = CHAR_CR;
            SLOT_LF:      ch = CHAR_LF;
            default:      ch = end_char(end_idx);
        endcase
    end

    // Next slot; skips nothing inside a segment
    assign n_slot = r_slot + 5'd1;

    // Sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_slot <= SLOT_COLON;
        end else if (take) begin
            r_busy <= 1'b1;
            r_slot <= i_plan.hdr ? SLOT_COLON : SLOT_DATA_HI;
        end else if (r_busy && adv) begin
            if (fin) begin
                r_busy <= 1'b0;
            end else begin
                r_slot <= n_slot;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_plan <= i_plan;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (adv) begin
            r_ovalid <= r_busy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && r_busy) begin
            r_ochar <= ch;
            r_olast <= fin;
        end
    end

    assign o_m_axis_tvalid = r_ovalid;
    assign o_m_axis_tdata  = {1'b0, r_ochar};
    assign o_m_axis_tlast  = r_olast;

`ifndef SYNTH
    a_slot_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_slot <= SLOT_LAST))
        else $error("slot beyond end record");
    a_no_cks_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && !r_plan.close) |-> (r_slot <= SLOT_DATA_LO))
        else $error("checksum slot reached on an open record");
    a_last_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && r_plan.last) |-> r_plan.close)
        else $error("image end without record close");
    a_take_on_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && adv && fin && !take) |=> !r_busy)
        else $error("sequencer stayed busy after final slot");
`endif

endmodule
